>>> design/vector3_arithmetic_unit_top_macros.svh
// ----------------------------------------------------------------------------
// vector3 arithmetic unit assertion macros
// concurrent check wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define VECTOR3_ARITHMETIC_UNIT_TOP_MACROS_SVH

`ifndef SYNTH
`define VAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vau check failed");
`define VAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vau check failed");
`else
`define VAU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define VAU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/vau_pkg.sv
// ----------------------------------------------------------------------------
// vau_pkg
// shared constants and codes of the vector3 arithmetic unit
// ----------------------------------------------------------------------------
package vau_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [2:0] {
        OP_ADD       = 3'd0,
        OP_SUB       = 3'd1,
        OP_SCALE     = 3'd2,
        OP_DIVIDE    = 3'd3,
        OP_LENGTH    = 3'd4,
        OP_NORMALIZE = 3'd5,
        OP_DOT       = 3'd6,
        OP_CROSS     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

endpackage

>>> design/vector3_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_top
// 3d vector alu on signed fixed point: add, sub, scale, divide, length,
// normalize, dot and cross, saturating
//
//  channel   direction  handshake          payload
//  request   in         i_valid / o_stall  i_req_type, i_ax..i_bz, i_scalar_in
//  result    out        o_valid / i_stall  o_rx, o_ry, o_rz, o_scalar_out, o_status
//
// one item per cycle while the result is not stalled; every item passes through the
// multiply and combine registers, the square root (DATA_WIDTH stages), the divider
// (DATA_WIDTH+FRAC_BITS stages) and the result register
// synchronous active-low reset clears the valid bits only
// a stalled result holds the whole pipeline; o_stall is high only then
// ----------------------------------------------------------------------------
`include "vector3_arithmetic_unit_top_macros.svh"

module vector3_arithmetic_unit_top #(
    parameter int DATA_WIDTH = vau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = vau_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [2:0]                   i_req_type,
    input  logic signed [DATA_WIDTH-1:0] i_ax,
    input  logic signed [DATA_WIDTH-1:0] i_ay,
    input  logic signed [DATA_WIDTH-1:0] i_az,
    input  logic signed [DATA_WIDTH-1:0] i_bx,
    input  logic signed [DATA_WIDTH-1:0] i_by,
    input  logic signed [DATA_WIDTH-1:0] i_bz,
    input  logic signed [DATA_WIDTH-1:0] i_scalar_in,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_rx,
    output logic signed [DATA_WIDTH-1:0] o_ry,
    output logic signed [DATA_WIDTH-1:0] o_rz,
    output logic signed [DATA_WIDTH-1:0] o_scalar_out,
    output logic [1:0]                   o_status
);
    import vau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int QW = W + F;
    localparam int VW = (2*W + 3 > W + F + 2) ? 2*W + 3 : W + F + 2;
    localparam logic signed [VW-1:0] DMAX = {{(VW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [VW-1:0] DMIN = {{(VW-W+1){1'b1}}, {(W-1){1'b0}}};

    typedef struct packed {
        t_op              op;
        logic [2:0][W-1:0] a;
        logic [W-1:0]     s;
        logic [2:0][W-1:0] r;
        logic [W-1:0]     sc;
        logic             ovf;
    } t_sq_side;

    typedef struct packed {
        t_op              op;
        logic [2:0][W-1:0] r;
        logic [W-1:0]     sc;
        logic             ovf;
        logic [2:0]       neg;
        logic             zero;
        logic             dz;
    } t_dv_side;

    // {overflow, clamped value}
    function automatic logic [W:0] sat_fn(input logic signed [VW-1:0] v);
        logic [W:0] res;
        if (v > DMAX) begin
            res = {1'b1, DMAX[W-1:0]};
        end else if (v < DMIN) begin
            res = {1'b1, DMIN[W-1:0]};
        end else begin
            res = {1'b0, v[W-1:0]};
        end
        return res;
    endfunction

    logic en;

    // multiply stage
    logic [2:0][W-1:0]   c_a;
    logic [2:0][W-1:0]   c_b;
    logic [2:0][W-1:0]   c_ma;
    logic [2:0][W-1:0]   c_mb;
    logic [2:0][2*W-1:0] n_a_pe;
    logic [2:0][2*W-1:0] n_a_po;
    logic [2:0][W:0]     n_a_as;
    t_op                 c_op;

    logic                r_a_valid;
    t_op                 r_a_op;
    logic [2:0][W-1:0]   r_a_a;
    logic [W-1:0]        r_a_s;
    logic [2:0][2*W-1:0] r_a_pe;
    logic [2:0][2*W-1:0] r_a_po;
    logic [2:0][W:0]     r_a_as;

    assign en   = !o_valid || !i_stall;
    assign c_op = t_op'(i_req_type);
    assign c_a  = {i_az, i_ay, i_ax};
    assign c_b  = {i_bz, i_by, i_bx};

    for (genvar k = 0; k < 3; k++) begin : g_mul
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;

        always_comb begin
            c_ma[k] = (c_op == OP_CROSS) ? c_a[K1] : c_a[k];
            case (c_op)
                OP_CROSS: c_mb[k] = c_b[K2];
                OP_SCALE: c_mb[k] = i_scalar_in;
                OP_DOT:   c_mb[k] = c_b[k];
                default:  c_mb[k] = c_a[k];
            endcase
        end

        assign n_a_pe[k] = $signed(c_ma[k]) * $signed(c_mb[k]);
        assign n_a_po[k] = $signed(c_a[K2]) * $signed(c_b[K1]);
        assign n_a_as[k] = (c_op == OP_SUB)
            ? ({c_a[k][W-1], c_a[k]} - {c_b[k][W-1], c_b[k]})
            : ({c_a[k][W-1], c_a[k]} + {c_b[k][W-1], c_b[k]});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_op <= c_op;
            r_a_a  <= c_a;
            r_a_s  <= i_scalar_in;
            r_a_pe <= n_a_pe;
            r_a_po <= n_a_po;
            r_a_as <= n_a_as;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
        end
    end

    // combine, round and clamp
    t_sq_side       n_b_side;
    logic [2*W-1:0] n_b_rad;
    logic           r_b_valid;
    t_sq_side       r_b_side;
    logic [2*W-1:0] r_b_rad;

    always_comb begin
        logic signed [VW-1:0] pe_x [3];
        logic signed [VW-1:0] po_x [3];
        logic signed [VW-1:0] as_x [3];
        logic signed [VW-1:0] v;
        logic signed [VW-1:0] tot;
        logic [W:0]           sr;
        logic [W:0]           dsr;
        logic                 vovf;
        vovf = 1'b0;
        n_b_side.op  = r_a_op;
        n_b_side.a   = r_a_a;
        n_b_side.s   = r_a_s;
        for (int k = 0; k < 3; k++) begin
            pe_x[k] = {{(VW-2*W){r_a_pe[k][2*W-1]}}, r_a_pe[k]};
            po_x[k] = {{(VW-2*W){r_a_po[k][2*W-1]}}, r_a_po[k]};
            as_x[k] = {{(VW-W-1){r_a_as[k][W]}}, r_a_as[k]};
            case (r_a_op)
                OP_ADD:   v = as_x[k];
                OP_SUB:   v = as_x[k];
                OP_SCALE: v = pe_x[k] >>> F;
                OP_CROSS: v = (pe_x[k] - po_x[k]) >>> F;
                default:  v = '0;
            endcase
            sr = sat_fn(v);
            n_b_side.r[k] = sr[W-1:0];
            vovf = vovf | sr[W];
        end
        tot = pe_x[0] + pe_x[1] + pe_x[2];
        dsr = sat_fn(tot >>> F);
        n_b_side.sc  = (r_a_op == OP_DOT) ? dsr[W-1:0] : '0;
        n_b_side.ovf = vovf | ((r_a_op == OP_DOT) & dsr[W]);
        n_b_rad      = tot[2*W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_side <= n_b_side;
            r_b_rad  <= n_b_rad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    // square root of the sum of squares
    logic     sq_valid;
    logic [W-1:0] sq_root;
    t_sq_side sq_side;

    vau_sqrt_pipe #(
        .DATA_WIDTH (W),
        .SIDE_W     ($bits(t_sq_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_b_valid),
        .i_rad   (r_b_rad),
        .i_side  (r_b_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // divider set-up
    t_dv_side           c_dv_side;
    logic [2:0][QW-1:0] c_num;
    logic [W-1:0]       c_den;

    always_comb begin
        logic [W-1:0] a_abs;
        logic [W-1:0] s_abs;
        logic         is_divide;
        is_divide       = (sq_side.op == OP_DIVIDE);
        s_abs           = sq_side.s[W-1] ? (W)'(-sq_side.s) : sq_side.s;
        c_dv_side.op    = sq_side.op;
        c_dv_side.r     = sq_side.r;
        c_dv_side.sc    = sq_side.sc;
        c_dv_side.ovf   = sq_side.ovf;
        if (sq_side.op == OP_LENGTH) begin
            c_dv_side.sc  = sq_root[W-1] ? DMAX[W-1:0] : sq_root;
            c_dv_side.ovf = sq_root[W-1];
        end
        for (int k = 0; k < 3; k++) begin
            a_abs = sq_side.a[k][W-1] ? (W)'(-sq_side.a[k]) : sq_side.a[k];
            c_num[k] = {a_abs, {F{1'b0}}};
            c_dv_side.neg[k] = sq_side.a[k][W-1] ^ (is_divide & sq_side.s[W-1]);
        end
        c_den          = is_divide ? s_abs : sq_root;
        c_dv_side.dz   = is_divide && (sq_side.s == '0);
        c_dv_side.zero = c_dv_side.dz || ((sq_side.op == OP_NORMALIZE) && (sq_root == '0));
    end

    logic               dv_valid;
    logic [2:0][QW-1:0] dv_quot;
    t_dv_side           dv_side;

    vau_div_pipe #(
        .DATA_WIDTH (W),
        .FRAC_BITS  (F),
        .SIDE_W     ($bits(t_dv_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_num   (c_num),
        .i_den   (c_den),
        .i_side  (c_dv_side),
        .o_valid (dv_valid),
        .o_quot  (dv_quot),
        .o_side  (dv_side)
    );

    // sign, clamp and result register
    logic [2:0][W-1:0] n_o_r;
    t_status           n_o_status;
    logic              r_o_valid;
    logic [2:0][W-1:0] r_o_r;
    logic [W-1:0]      r_o_sc;
    t_status           r_o_status;

    always_comb begin
        logic signed [VW-1:0] v;
        logic [W:0]           sr;
        logic                 is_div;
        logic                 qovf;
        logic                 ovf;
        is_div = (dv_side.op == OP_DIVIDE) || (dv_side.op == OP_NORMALIZE);
        qovf   = 1'b0;
        for (int k = 0; k < 3; k++) begin
            v  = {{(VW-QW){1'b0}}, dv_quot[k]};
            v  = dv_side.neg[k] ? -v : v;
            sr = sat_fn(v);
            qovf = qovf | sr[W];
            if (!is_div) begin
                n_o_r[k] = dv_side.r[k];
            end else if (dv_side.zero) begin
                n_o_r[k] = '0;
            end else begin
                n_o_r[k] = sr[W-1:0];
            end
        end
        ovf = is_div ? (!dv_side.zero && qovf) : dv_side.ovf;
        if (dv_side.dz) begin
            n_o_status = ST_DIV_ZERO;
        end else if (ovf) begin
            n_o_status = ST_OVERFLOW;
        end else begin
            n_o_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_r      <= n_o_r;
            r_o_sc     <= dv_side.sc;
            r_o_status <= n_o_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= dv_valid;
        end
    end

    assign o_stall      = !en;
    assign o_valid      = r_o_valid;
    assign o_rx         = r_o_r[0];
    assign o_ry         = r_o_r[1];
    assign o_rz         = r_o_r[2];
    assign o_scalar_out = r_o_sc;
    assign o_status     = r_o_status;

    `VAU_ASSERT_IMP(a_div_zero_clears, i_clk, i_rst_n, o_valid && (o_status == ST_DIV_ZERO), (o_rx == '0) && (o_ry == '0) && (o_rz == '0) && (o_scalar_out == '0))
    `VAU_ASSERT_IMP(a_stall_needs_result, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `VAU_ASSERT_NXT(a_valid_advances, i_clk, i_rst_n, r_a_valid && !o_stall, r_b_valid)

endmodule

>>> design/vau_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// vau_sqrt_pipe
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module vau_sqrt_pipe #(
    parameter int DATA_WIDTH = vau_pkg::DATA_WIDTH_DEF,
    parameter int SIDE_W     = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [2*DATA_WIDTH-1:0] i_rad,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic [DATA_WIDTH-1:0]   o_root,
    output logic [SIDE_W-1:0]       o_side
);
    localparam int W = DATA_WIDTH;

    logic [W+1:0]    r_rem   [W];
    logic [W-1:0]    r_root  [W];
    logic [2*W-1:0]  r_bits  [W];
    logic [SIDE_W-1:0] r_side [W];
    logic            r_valid [W];

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W+1:0]      c_rem;
        logic [W-1:0]      c_root;
        logic [2*W-1:0]    c_bits;
        logic [SIDE_W-1:0] c_side;
        logic              c_valid;
        logic [W+1:0]      c_t;
        logic [W+1:0]      c_trial;
        logic              c_ge;
        logic [W+1:0]      n_rem;
        logic [W-1:0]      n_root;
        logic [2*W-1:0]    n_bits;

        if (k == 0) begin : g_first
            assign c_rem   = '0;
            assign c_root  = '0;
            assign c_bits  = i_rad;
            assign c_side  = i_side;
            assign c_valid = i_valid;
        end else begin : g_next
            assign c_rem   = r_rem[k-1];
            assign c_root  = r_root[k-1];
            assign c_bits  = r_bits[k-1];
            assign c_side  = r_side[k-1];
            assign c_valid = r_valid[k-1];
        end

        assign c_t     = {c_rem[W-1:0], c_bits[2*W-1 -: 2]};
        assign c_trial = {1'b0, c_root[W-2:0], 2'b01};
        assign c_ge    = (c_t >= c_trial);
        assign n_rem   = c_ge ? (c_t - c_trial) : c_t;
        assign n_root  = {c_root[W-2:0], c_ge};
        assign n_bits  = {c_bits[2*W-3:0], 2'b00};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_bits[k] <= n_bits;
                r_side[k] <= c_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= c_valid;
            end
        end
    end

    assign o_valid = r_valid[W-1];
    assign o_root  = r_root[W-1];
    assign o_side  = r_side[W-1];

endmodule

>>> design/vau_div_pipe.sv
// ----------------------------------------------------------------------------
// vau_div_pipe
// three-lane pipelined restoring divider on magnitudes, one quotient bit
// per stage, common divisor
// ----------------------------------------------------------------------------
module vau_div_pipe #(
    parameter int DATA_WIDTH = vau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = vau_pkg::FRAC_BITS_DEF,
    parameter int SIDE_W     = 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_valid,
    input  logic [2:0][DATA_WIDTH+FRAC_BITS-1:0]   i_num,
    input  logic [DATA_WIDTH-1:0]                  i_den,
    input  logic [SIDE_W-1:0]                      i_side,
    output logic                                   o_valid,
    output logic [2:0][DATA_WIDTH+FRAC_BITS-1:0]   o_quot,
    output logic [SIDE_W-1:0]                      o_side
);
    localparam int W  = DATA_WIDTH;
    localparam int QW = DATA_WIDTH + FRAC_BITS;

    logic [2:0][W-1:0]  r_rem  [QW];
    logic [2:0][QW-1:0] r_nq   [QW];
    logic [W-1:0]       r_den  [QW];
    logic [SIDE_W-1:0]  r_side [QW];
    logic               r_valid[QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [2:0][W-1:0]  c_rem;
        logic [2:0][QW-1:0] c_nq;
        logic [W-1:0]       c_den;
        logic [SIDE_W-1:0]  c_side;
        logic               c_valid;
        logic [2:0][W-1:0]  n_rem;
        logic [2:0][QW-1:0] n_nq;

        if (k == 0) begin : g_first
            assign c_rem   = '0;
            assign c_nq    = i_num;
            assign c_den   = i_den;
            assign c_side  = i_side;
            assign c_valid = i_valid;
        end else begin : g_next
            assign c_rem   = r_rem[k-1];
            assign c_nq    = r_nq[k-1];
            assign c_den   = r_den[k-1];
            assign c_side  = r_side[k-1];
            assign c_valid = r_valid[k-1];
        end

        for (genvar j = 0; j < 3; j++) begin : g_lane
            logic [W:0] c_t;
            logic [W:0] c_diff;
            logic       c_ge;

            assign c_t      = {c_rem[j], c_nq[j][QW-1]};
            assign c_diff   = c_t - {1'b0, c_den};
            assign c_ge     = (c_t >= {1'b0, c_den});
            assign n_rem[j] = c_ge ? c_diff[W-1:0] : c_t[W-1:0];
            assign n_nq[j]  = {c_nq[j][QW-2:0], c_ge};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_nq[k]   <= n_nq;
                r_den[k]  <= c_den;
                r_side[k] <= c_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= c_valid;
            end
        end
    end

    assign o_valid = r_valid[QW-1];
    assign o_quot  = r_nq[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the vector3 arithmetic unit: a queue-fed driver
// sends directed and random requests, a monitor compares every result with
// a local prediction of the fixed-point arithmetic, with random idling on
// both channels
// ----------------------------------------------------------------------------
module tb_top;
    import vau_pkg::*;

    typedef logic signed [31:0] t_word;
    typedef logic signed [95:0] t_wide;

    typedef struct {
        t_op   op;
        t_word a [3];
        t_word b [3];
        t_word s;
    } t_req;

    typedef struct {
        t_word   r [3];
        t_word   sc;
        t_status st;
    } t_res;

    logic  i_clk, i_rst_n, i_valid, i_stall, o_stall, o_valid;
    logic [2:0] i_req_type;
    t_word i_ax, i_ay, i_az, i_bx, i_by, i_bz, i_scalar_in;
    t_word o_rx, o_ry, o_rz, o_scalar_out;
    logic [1:0] o_status;

    t_req pending_reqs [$];
    t_res expected_results [$];
    int   errors, accepted, checked;
    int   op_count [8];
    bit   taken;

    vector3_arithmetic_unit_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_word clamp(input t_wide v, inout bit ovf);
        if (v > t_wide'(32'sh7fffffff)) begin
            ovf = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -t_wide'(33'sh080000000)) begin
            ovf = 1'b1;
            return 32'sh80000000;
        end
        return t_word'(v);
    endfunction

    function automatic logic [65:0] int_sqrt(input logic [65:0] n);
        logic [65:0] res, bt;
        res = '0;
        bt  = 66'd1 << 64;
        while (bt > n) bt = bt >> 2;
        while (bt != 0) begin
            if (n >= res + bt) begin
                n   = n - res - bt;
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic t_res vector_result(input t_req q);
        t_res  e;
        bit    ovf;
        t_wide a [3], b [3], sum, len;
        ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            a[i] = q.a[i];
            b[i] = q.b[i];
            e.r[i] = '0;
        end
        e.sc = '0;
        e.st = ST_OK;
        case (q.op)
            OP_ADD:
                for (int i = 0; i < 3; i++) e.r[i] = clamp(a[i] + b[i], ovf);
            OP_SUB:
                for (int i = 0; i < 3; i++) e.r[i] = clamp(a[i] - b[i], ovf);
            OP_SCALE:
                for (int i = 0; i < 3; i++) e.r[i] = clamp((a[i] * t_wide'(q.s)) >>> 16, ovf);
            OP_DIVIDE:
                if (q.s == 0) e.st = ST_DIV_ZERO;
                else for (int i = 0; i < 3; i++)
                    e.r[i] = clamp((a[i] <<< 16) / t_wide'(q.s), ovf);
            OP_LENGTH: begin
                sum  = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                e.sc = clamp(t_wide'(int_sqrt(sum[65:0])), ovf);
            end
            OP_NORMALIZE: begin
                sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
                len = t_wide'(int_sqrt(sum[65:0]));
                if (len != 0)
                    for (int i = 0; i < 3; i++) e.r[i] = clamp((a[i] <<< 16) / len, ovf);
            end
            OP_DOT:
                e.sc = clamp((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> 16, ovf);
            default: begin
                e.r[0] = clamp((a[1] * b[2] - a[2] * b[1]) >>> 16, ovf);
                e.r[1] = clamp((a[2] * b[0] - a[0] * b[2]) >>> 16, ovf);
                e.r[2] = clamp((a[0] * b[1] - a[1] * b[0]) >>> 16, ovf);
            end
        endcase
        if (e.st == ST_OK && ovf) e.st = ST_OVERFLOW;
        return e;
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2:       return '0;
            3, 4:    return t_word'($urandom);
            5:       return t_word'($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
            default: return t_word'($urandom_range(0, 32'h03ffffff)) - 32'sh02000000;
        endcase
    endfunction

    task automatic add_req(input t_op op, input t_word ax, ay, az, bx, by, bz, s);
        t_req q;
        q.op = op;
        q.a  = '{ax, ay, az};
        q.b  = '{bx, by, bz};
        q.s  = s;
        pending_reqs.push_back(q);
    endtask

    task automatic report(input string what, input t_word got, input t_word want);
        errors++;
        $display("mismatch on result %0d, %s: got %h, expected %h", checked, what, got, want);
    endtask

    function automatic int phase();
        return accepted < 150 ? 0 : (accepted < 300 ? 1 : 2);
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            if (!i_valid || taken) begin
                taken = 1'b0;
                if (pending_reqs.size() == 0 ||
                    (phase() == 0 && $urandom_range(0, 99) < 10) ||
                    (phase() == 1 && $urandom_range(0, 99) < 60)) begin
                    i_valid <= 1'b0;
                end else begin
                    i_valid     <= 1'b1;
                    i_req_type  <= pending_reqs[0].op;
                    i_ax        <= pending_reqs[0].a[0];
                    i_ay        <= pending_reqs[0].a[1];
                    i_az        <= pending_reqs[0].a[2];
                    i_bx        <= pending_reqs[0].b[0];
                    i_by        <= pending_reqs[0].b[1];
                    i_bz        <= pending_reqs[0].b[2];
                    i_scalar_in <= pending_reqs[0].s;
                end
            end
            i_stall <= (phase() == 0 && $urandom_range(0, 99) < 60) ||
                       (phase() == 1 && $urandom_range(0, 99) < 10);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && i_valid && !o_stall) begin
            expected_results.push_back(vector_result(pending_reqs[0]));
            op_count[pending_reqs[0].op]++;
            void'(pending_reqs.pop_front());
            accepted++;
            taken = 1'b1;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("unexpected result item");
            end else begin
                e = expected_results.pop_front();
                if (o_rx !== e.r[0]) report("rx", o_rx, e.r[0]);
                if (o_ry !== e.r[1]) report("ry", o_ry, e.r[1]);
                if (o_rz !== e.r[2]) report("rz", o_rz, e.r[2]);
                if (o_scalar_out !== e.sc) report("scalar_out", o_scalar_out, e.sc);
                if (o_status !== e.st) report("status", t_word'(o_status), t_word'(e.st));
            end
            checked++;
        end
    end

    initial begin
        t_op op;
        errors = 0;
        accepted = 0;
        checked = 0;
        taken = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_req_type = '0;
        {i_ax, i_ay, i_az, i_bx, i_by, i_bz, i_scalar_in} = '0;
        foreach (op_count[i]) op_count[i] = 0;

        // directed corners
        add_req(OP_ADD, 32'sh7fffffff, 32'sh80000000, 1, 1, -1, 2, 0);
        add_req(OP_ADD, 32'sh7fffffff, 0, 5, 32'sh7fffffff, 0, -5, 0);
        add_req(OP_SUB, 32'sh80000000, 32'sh7fffffff, 0, 1, -1, 32'sh80000000, 0);
        add_req(OP_SCALE, 32'sh00010000, -32'sh00010000, 3, 0, 0, 0, 32'sh00020000);
        add_req(OP_SCALE, 32'sh7fffffff, 32'sh80000000, -1, 0, 0, 0, 32'sh80000000);
        add_req(OP_SCALE, -1, 1, -3, 0, 0, 0, 1);
        add_req(OP_DIVIDE, 32'sh00030000, 7, -7, 0, 0, 0, 0);
        add_req(OP_DIVIDE, 32'sh00030000, -7, 7, 0, 0, 0, 32'sh00020000);
        add_req(OP_DIVIDE, 32'sh7fffffff, 32'sh80000000, 1, 0, 0, 0, 1);
        add_req(OP_DIVIDE, 32'sh80000000, 5, -5, 0, 0, 0, -1);
        add_req(OP_LENGTH, 0, 0, 0, 0, 0, 0, 0);
        add_req(OP_LENGTH, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0);
        add_req(OP_LENGTH, 32'sh00030000, 32'sh00040000, 0, 0, 0, 0, 0);
        add_req(OP_NORMALIZE, 0, 0, 0, 1, 2, 3, 4);
        add_req(OP_NORMALIZE, 32'sh80000000, 0, 0, 0, 0, 0, 0);
        add_req(OP_NORMALIZE, 1, -1, 1, 0, 0, 0, 0);
        add_req(OP_NORMALIZE, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0, 0, 0);
        add_req(OP_DOT, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
        add_req(OP_DOT, -1, 1, -1, 1, 1, 1, 0);
        add_req(OP_DOT, 32'sh00010000, 32'sh00020000, 32'sh00030000, 4, -5, 6, 0);
        add_req(OP_CROSS, 32'sh00010000, 0, 0, 0, 32'sh00010000, 0, 0);
        add_req(OP_CROSS, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0);
        add_req(OP_CROSS, -1, 2, -3, 3, -2, 1, 0);

        for (int n = 0; n < 450; n++) begin
            op = t_op'($urandom_range(0, 7));
            add_req(op, pick_word(), pick_word(), pick_word(), pick_word(), pick_word(),
                    pick_word(), (op == OP_DIVIDE && $urandom_range(0, 9) == 0) ? '0 : pick_word());
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_reqs.size() == 0 && expected_results.size() == 0);
        repeat (100) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            errors++;
            $display("%0d expected results never arrived", expected_results.size());
        end
        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 accepted, checked, errors);
        $display("ops add %0d sub %0d scale %0d div %0d len %0d norm %0d dot %0d cross %0d",
                 op_count[0], op_count[1], op_count[2], op_count[3],
                 op_count[4], op_count[5], op_count[6], op_count[7]);
        if (errors == 0) $display("vector3_arithmetic_unit_top test passed");
        else $display("vector3_arithmetic_unit_top test failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("vector3_arithmetic_unit_top test failed");
        $finish;
    end
endmodule

>>> sim.f
+incdir+design
design/vau_pkg.sv
design/vau_sqrt_pipe.sv
design/vau_div_pipe.sv
design/vector3_arithmetic_unit_top.sv
test/tb_top.sv
